[src/chs_pkg.sv]
// chs_pkg: word types and sequencer states for the chained hash set
// no dependencies; imported by chained_hash_set_top and tb

package chs_pkg;

   // fixed field widths
   localparam int unsigned KEY_W = 63;

   // request word: find or insert one key
   typedef struct packed {
      logic             mode;
      logic [KEY_W-1:0] key;
   } req_word_type;

   // response word
   typedef struct packed {
      logic answer;
      logic status;
   } rsp_word_type;

   // request modes
   localparam logic MODE_FIND   = 1'b0;
   localparam logic MODE_INSERT = 1'b1;

   // response status codes
   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_FULL = 1'b1;

   // sequencer states, one-hot
   typedef enum logic [8:0] {
      ST_CLEAR  = 9'b000000001,
      ST_IDLE   = 9'b000000010,
      ST_MOD    = 9'b000000100,
      ST_HREAD  = 9'b000001000,
      ST_HLOAD  = 9'b000010000,
      ST_WALK   = 9'b000100000,
      ST_NWAIT  = 9'b001000000,
      ST_DECIDE = 9'b010000000,
      ST_RESP   = 9'b100000000
   } state_type;

endpackage

[src/chained_hash_set_top.sv]
// Flow: an accepted word passes ST_MOD (the bucket; a serial remainder taken digit by digit
// when BUCKETS is not a power of two), ST_HREAD, ST_HLOAD, ST_WALK and ST_NWAIT per chain
// node read, ST_DECIDE and ST_RESP, which registers the response word.
// One word at a time: the next word is taken once the response is registered, and ST_RESP
// waits while the output stalls. Reset: synchronous, active high; a clearing pass (ST_CLEAR)
// empties the bucket heads, and no request is taken until it ends.

module chained_hash_set_top #(
   parameter int unsigned BUCKETS   = 1024,
   parameter int unsigned POOL_SIZE = 4096
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  chs_pkg::req_word_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output chs_pkg::rsp_word_type rsp_data
);
   import chs_pkg::*;

   // widths derived from the parameters
   localparam int unsigned BW     = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
   localparam int unsigned RW     = BW + 1;
   localparam int unsigned LW     = $clog2(POOL_SIZE + 1);
   localparam int unsigned NW     = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
   localparam bit          IS_POW2 = ((BUCKETS & (BUCKETS - 1)) == 0);
   localparam int unsigned DIGIT  = 4;
   localparam int unsigned SHW    = 64;
   localparam int unsigned STEPS  = SHW / DIGIT;
   localparam int unsigned CW     = $clog2(STEPS);

   localparam logic [RW-1:0] BUCKETS_R = RW'(BUCKETS);
   localparam logic [BW-1:0] LAST_B    = BW'(BUCKETS - 1);
   localparam logic [LW-1:0] POOL_L    = LW'(POOL_SIZE);

   // memories
   logic [LW-1:0]    heads_mem [BUCKETS];
   logic [KEY_W-1:0] keys_mem  [POOL_SIZE];
   logic [LW-1:0]    links_mem [POOL_SIZE];

   // registers
   state_type        state_ff, state_in;
   logic             mode_ff, mode_in;
   logic [KEY_W-1:0] key_ff, key_in;
   logic [SHW-1:0]   shift_ff, shift_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic [BW-1:0]    bucket_ff, bucket_in;
   logic [LW-1:0]    head_ff, head_in;
   logic [LW-1:0]    link_ff, link_in;
   logic [LW-1:0]    steps_ff, steps_in;
   logic [LW-1:0]    used_ff, used_in;
   logic             found_ff, found_in;
   logic             ans_ff, ans_in;
   logic             stat_ff, stat_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_word_type     rsp_word_ff, rsp_word_in;

   // registered memory read data
   logic [LW-1:0]    head_q;
   logic [KEY_W-1:0] nkey_q;
   logic [LW-1:0]    nlink_q;

   // memory write controls
   logic             head_we;
   logic [BW-1:0]    head_waddr;
   logic [LW-1:0]    head_wdata;
   logic             node_we;
   logic [NW-1:0]    node_addr;
   logic [NW-1:0]    node_waddr;

   // remainder digit step and walk status
   logic [BW-1:0]    rem_next;
   logic [RW-1:0]    rem_t;
   logic             pool_full;
   logic             walk_end;
   logic             accept;
   logic             rsp_free;

   assign accept    = req_valid && (state_ff == ST_IDLE);
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_word_ff;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign pool_full = (used_ff == POOL_L);
   assign walk_end  = (link_ff == '0) || (link_ff > POOL_L) || (steps_ff == POOL_L);
   assign node_addr = NW'(link_ff - LW'(1));

   // one digit of the key into the running remainder, compare-subtract per bit
   always_comb begin
      rem_next = bucket_ff;
      rem_t    = '0;
      for (int i = 0; i < DIGIT; i++) begin
         rem_t = {rem_next, shift_ff[SHW-1-i]};
         if (rem_t >= BUCKETS_R) begin
            rem_t = rem_t - BUCKETS_R;
         end
         rem_next = rem_t[BW-1:0];
      end
   end

   // sequencer next state and datapath
   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      key_in       = key_ff;
      shift_in     = shift_ff;
      cnt_in       = cnt_ff;
      bucket_in    = bucket_ff;
      head_in      = head_ff;
      link_in      = link_ff;
      steps_in     = steps_ff;
      used_in      = used_ff;
      found_in     = found_ff;
      ans_in       = ans_ff;
      stat_in      = stat_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_word_in  = rsp_word_ff;
      head_we      = 1'b0;
      head_waddr   = bucket_ff;
      head_wdata   = '0;
      node_we      = 1'b0;
      node_waddr   = NW'(used_ff);

      unique case (state_ff)
         ST_CLEAR: begin
            head_we = 1'b1;
            if (bucket_ff == LAST_B) begin
               state_in = ST_IDLE;
            end else begin
               bucket_in = bucket_ff + BW'(1);
            end
         end
         ST_IDLE: begin
            if (accept) begin
               mode_in   = req_data.mode;
               key_in    = req_data.key;
               shift_in  = {1'b0, req_data.key};
               cnt_in    = '0;
               bucket_in = '0;
               state_in  = ST_MOD;
            end
         end
         ST_MOD: begin
            if (IS_POW2) begin
               bucket_in = (BUCKETS == 1) ? '0 : key_ff[BW-1:0];
               state_in  = ST_HREAD;
            end else begin
               bucket_in = rem_next;
               shift_in  = shift_ff << DIGIT;
               cnt_in    = cnt_ff + CW'(1);
               if (cnt_ff == CW'(STEPS - 1)) begin
                  state_in = ST_HREAD;
               end
            end
         end
         ST_HREAD: begin
            state_in = ST_HLOAD;
         end
         ST_HLOAD: begin
            head_in  = head_q;
            link_in  = head_q;
            steps_in = '0;
            found_in = 1'b0;
            state_in = ST_WALK;
         end
         ST_WALK: begin
            if (walk_end) begin
               state_in = ST_DECIDE;
            end else begin
               state_in = ST_NWAIT;
            end
         end
         ST_NWAIT: begin
            if (nkey_q == key_ff) begin
               found_in = 1'b1;
               state_in = ST_DECIDE;
            end else begin
               link_in  = nlink_q;
               steps_in = steps_ff + LW'(1);
               state_in = ST_WALK;
            end
         end
         ST_DECIDE: begin
            ans_in  = 1'b0;
            stat_in = STATUS_OK;
            if (mode_ff == MODE_FIND) begin
               ans_in = found_ff;
            end else if (!found_ff) begin
               if (pool_full) begin
                  stat_in = STATUS_FULL;
               end else begin
                  node_we    = 1'b1;
                  head_we    = 1'b1;
                  head_wdata = used_ff + LW'(1);
                  used_in    = used_ff + LW'(1);
                  ans_in     = 1'b1;
               end
            end
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (rsp_free) begin
               rsp_valid_in       = 1'b1;
               rsp_word_in.answer = ans_ff;
               rsp_word_in.status = stat_ff;
               state_in           = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         bucket_ff    <= '0;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         bucket_ff    <= bucket_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      mode_ff     <= mode_in;
      key_ff      <= key_in;
      shift_ff    <= shift_in;
      cnt_ff      <= cnt_in;
      head_ff     <= head_in;
      link_ff     <= link_in;
      steps_ff    <= steps_in;
      found_ff    <= found_in;
      ans_ff      <= ans_in;
      stat_ff     <= stat_in;
      rsp_word_ff <= rsp_word_in;
   end

   // bucket head memory
   always_ff @(posedge clock) begin
      if (head_we) begin
         heads_mem[head_waddr] <= head_wdata;
      end
      head_q <= heads_mem[bucket_ff];
   end

   // node key memory
   always_ff @(posedge clock) begin
      if (node_we) begin
         keys_mem[node_waddr] <= key_ff;
      end
      nkey_q <= keys_mem[node_addr];
   end

   // node link memory, new node points at the old chain head
   always_ff @(posedge clock) begin
      if (node_we) begin
         links_mem[node_waddr] <= head_ff;
      end
      nlink_q <= links_mem[node_addr];
   end

endmodule

[bench/tb.sv]
// tb: self-checking bench for chained_hash_set_top, find and insert words on a hash set
// depends on chs_pkg for word types, modes and status codes
`timescale 1ns / 100ps

module tb;
   import chs_pkg::*;

   localparam int unsigned BUCKETS    = 1024;
   localparam int unsigned POOL_SIZE  = 4096;
   localparam int unsigned LINK_W     = $clog2(POOL_SIZE + 1);
   localparam int unsigned BKT_W      = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
   localparam int unsigned NODE_W     = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
   localparam int unsigned RAND_OPS   = 1000;
   localparam int unsigned FILL_OPS   = 300;
   localparam int unsigned TAIL_WAIT  = 100;
   localparam int unsigned CYCLE_CAP  = 3000000;
   localparam logic [KEY_W-1:0] FILL_BASE = KEY_W'(64'h1_0000_0000);

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_word_type req_data = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_word_type rsp_data;

   chained_hash_set_top #(
      .BUCKETS   (BUCKETS),
      .POOL_SIZE (POOL_SIZE)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // clock, 2 ns period
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // shadow copy of the set
   logic [LINK_W-1:0] bucket_first [BUCKETS] = '{default: '0};
   logic [KEY_W-1:0]  node_key     [POOL_SIZE];
   logic [LINK_W-1:0] node_next    [POOL_SIZE];
   int unsigned       nodes_taken = 0;

   req_word_type      req_backlog [$];
   rsp_word_type      answers_due [$];
   logic [KEY_W-1:0]  keys_inserted [$];
   int unsigned       words_taken = 0;
   int unsigned       cycle_count = 0;
   int unsigned       errors = 0;

   // walk one chain looking for the key
   function automatic logic key_held(logic [KEY_W-1:0] k);
      logic [LINK_W-1:0] link;
      int unsigned       steps;
      link  = bucket_first[BKT_W'(k % BUCKETS)];
      steps = 0;
      while (link != '0 && link <= LINK_W'(POOL_SIZE) && steps < POOL_SIZE) begin
         if (node_key[NODE_W'(link - 1'b1)] == k) return 1'b1;
         link = node_next[NODE_W'(link - 1'b1)];
         steps++;
      end
      return 1'b0;
   endfunction

   // apply one find or insert to the shadow set, return the expected word
   function automatic rsp_word_type set_op_result(req_word_type w);
      rsp_word_type     r;
      logic [BKT_W-1:0] b;
      r.answer = 1'b0;
      r.status = STATUS_OK;
      if (w.mode == MODE_FIND) begin
         r.answer = key_held(w.key);
      end else if (!key_held(w.key)) begin
         if (nodes_taken >= POOL_SIZE) begin
            r.status = STATUS_FULL;
         end else begin
            b = BKT_W'(w.key % BUCKETS);
            node_key[NODE_W'(nodes_taken)]  = w.key;
            node_next[NODE_W'(nodes_taken)] = bucket_first[b];
            nodes_taken++;
            bucket_first[b] = LINK_W'(nodes_taken);
            r.answer = 1'b1;
         end
      end
      return r;
   endfunction

   // idle length: mostly none, a few long; none at all in calm stretches
   function automatic int unsigned pause_length();
      int unsigned r;
      if ((cycle_count / 3000) % 4 == 3) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 30);
   endfunction

   function automatic logic [KEY_W-1:0] any_key();
      return KEY_W'({$urandom, $urandom});
   endfunction

   task automatic queue_op(logic mode, logic [KEY_W-1:0] k);
      req_word_type w;
      w.mode = mode;
      w.key  = k;
      req_backlog.push_back(w);
      if (mode == MODE_INSERT) keys_inserted.push_back(k);
   endtask

   // cycle counter and run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_CAP) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // driver: offer backlog words with random gaps, predict on acceptance
   int unsigned gap_left = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = 0;
      end else begin
         if (req_valid && !req_stall) begin
            answers_due.push_back(set_op_result(req_data));
            words_taken <= words_taken + 1;
         end
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (req_backlog.size() > 0) begin
               req_data  <= req_backlog.pop_front();
               req_valid <= 1'b1;
               gap_left = pause_length();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor: check each response word, drive random stalls and two long holds
   int unsigned stall_left = 0;
   int unsigned hold_left = 0;
   int unsigned holds_done = 0;
   always @(posedge clock) begin
      rsp_word_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (answers_due.size() == 0) begin
               $error("unexpected word: answer %0b status %0b", rsp_data.answer,
                      rsp_data.status);
               errors++;
            end else begin
               want = answers_due.pop_front();
               if (rsp_data.answer !== want.answer) begin
                  $error("answer: expected %0b, got %0b", want.answer, rsp_data.answer);
                  errors++;
               end
               if (rsp_data.status !== want.status) begin
                  $error("status: expected %0b, got %0b", want.status, rsp_data.status);
                  errors++;
               end
            end
         end
         // long holds so the block backs up onto its input
         if ((holds_done == 0 && words_taken >= 200) ||
             (holds_done == 1 && words_taken >= 1000)) begin
            hold_left = 400;
            holds_done++;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            stall_left = pause_length();
            rsp_stall <= 1'b0;
         end
      end
   end

   // stimulus and end of run
   initial begin
      logic [KEY_W-1:0] k;
      int unsigned      r;

      // directed: empty set, duplicates, extremes, shared chains
      queue_op(MODE_FIND,   '0);
      queue_op(MODE_INSERT, '0);
      queue_op(MODE_INSERT, '0);
      queue_op(MODE_FIND,   '0);
      queue_op(MODE_INSERT, {KEY_W{1'b1}});
      queue_op(MODE_FIND,   {KEY_W{1'b1}});
      queue_op(MODE_FIND,   {KEY_W{1'b1}} - KEY_W'(BUCKETS));
      queue_op(MODE_INSERT, KEY_W'(BUCKETS));
      queue_op(MODE_INSERT, KEY_W'(2 * BUCKETS));
      queue_op(MODE_FIND,   '0);
      queue_op(MODE_FIND,   KEY_W'(BUCKETS));
      queue_op(MODE_FIND,   KEY_W'(3 * BUCKETS));
      queue_op(MODE_INSERT, KEY_W'(BUCKETS));
      queue_op(MODE_INSERT, KEY_W'(1));
      queue_op(MODE_FIND,   KEY_W'(1));
      queue_op(MODE_INSERT, KEY_W'(64'h5555_5555_5555_5555));
      queue_op(MODE_INSERT, KEY_W'(64'h2AAA_AAAA_AAAA_AAAA));
      queue_op(MODE_FIND,   KEY_W'(64'h2AAA_AAAA_AAAA_AAAA));
      queue_op(MODE_INSERT, KEY_W'(1) << (KEY_W - 1));
      queue_op(MODE_FIND,   KEY_W'(1) << (KEY_W - 1));
      queue_op(MODE_FIND,   (KEY_W'(1) << (KEY_W - 1)) + KEY_W'(BUCKETS));

      // random mix: repeat keys, crowded small keys, wide keys
      repeat (RAND_OPS) begin
         r = $urandom_range(0, 99);
         if (r < 35) k = keys_inserted[$urandom_range(0, keys_inserted.size() - 1)];
         else if (r < 70) k = KEY_W'($urandom_range(0, 8191));
         else k = any_key();
         queue_op($urandom_range(0, 1) ? MODE_INSERT : MODE_FIND, k);
      end

      // a run of consecutive keys, one per bucket
      for (int unsigned i = 0; i < FILL_OPS; i++) queue_op(MODE_INSERT, FILL_BASE + KEY_W'(i));

      // finds and repeat inserts of the run, mixed with fresh wide keys
      for (int unsigned i = 0; i < 40; i++) begin
         k = FILL_BASE + KEY_W'($urandom_range(0, FILL_OPS - 1));
         queue_op(MODE_FIND, k);
         queue_op(MODE_INSERT, k);
         queue_op(MODE_INSERT, any_key());
      end
      queue_op(MODE_FIND, '0);
      queue_op(MODE_INSERT, {KEY_W{1'b1}});

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // drain, then let any stray word show up
      while (req_backlog.size() != 0 || req_valid || answers_due.size() != 0)
         @(negedge clock);
      repeat (TAIL_WAIT) @(negedge clock);

      if (answers_due.size() != 0)
         $error("%0d expected words never arrived", answers_due.size());
      if (errors == 0 && answers_due.size() == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

[chained_hash_set_top.f]
src/chs_pkg.sv
src/chained_hash_set_top.sv
bench/tb.sv
